// ===== design/jlfs_pkg.sv =====
`timescale 1ns / 1ps
// jlfs_pkg: types, character codes and limits shared by the frame splitter
// no dependencies; imported by jlfs_out_if, jlfs_frame_logic and the top level
package jlfs_pkg;

    localparam int BUFFER_BYTES = 256;

    // frame limit can never pass the buffer size less one, nor 255
    localparam int          CAP_INT   = (BUFFER_BYTES - 1 > 255) ? 255 : (BUFFER_BYTES - 1);
    localparam logic [7:0]  LIMIT_CAP = 8'(CAP_INT);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_OPEN   = 8'h7B;
    localparam logic [7:0] CH_CLOSE  = 8'h7D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    localparam logic [7:0] MAX_LEN_RESET = 8'hFF;

    typedef enum logic [1:0] {
        FE_NONE  = 2'd0,
        FE_LINE  = 2'd1,
        FE_BRACE = 2'd2
    } t_frame_end;

    typedef struct packed {
        logic [7:0] frame_count;
        logic [7:0] brace_depth;
        logic       inside_string;
        logic       escape_pending;
    } t_frame_state;

    typedef struct packed {
        logic       stored;
        logic [7:0] position;
        t_frame_end frame_end;
        logic [7:0] frame_length;
        logic       overflow_drop;
    } t_frame_result;

endpackage

// ===== design/jlfs_if.sv =====
`timescale 1ns / 1ps
// jlfs_in_if / jlfs_out_if: valid/ready channels of the frame splitter
// depends on jlfs_pkg for the frame end code type
interface jlfs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;

    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink   (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface jlfs_out_if;
    import jlfs_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       stored;
    logic [7:0] position;
    t_frame_end frame_end;
    logic [7:0] frame_length;
    logic       overflow_drop;
    logic       chunk_done;

    modport source (output valid, output out_byte, output stored, output position,
                    output frame_end, output frame_length, output overflow_drop,
                    output chunk_done, input ready);
    modport sink   (input valid, input out_byte, input stored, input position,
                    input frame_end, input frame_length, input overflow_drop,
                    input chunk_done, output ready);
endinterface

// ===== design/jlfs_frame_logic.sv =====
`timescale 1ns / 1ps
// jlfs_frame_logic: per-byte framing decision and next stream state
// depends on jlfs_pkg; combinational, used between the input and result registers
module jlfs_frame_logic
    import jlfs_pkg::*;
(
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_max_len,
    input  t_frame_state  i_state,
    output t_frame_result o_result,
    output t_frame_state  o_state_nxt
);

    logic [7:0]   limit;
    logic         is_term;
    logic [7:0]   count_inc;
    t_frame_state tracked;
    logic         closes;

    assign limit     = (i_max_len > LIMIT_CAP) ? LIMIT_CAP : i_max_len;
    assign is_term   = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign count_inc = i_state.frame_count + 8'd1;

    // string / escape / brace tracking for a stored byte
    always_comb begin
        tracked             = i_state;
        tracked.frame_count = count_inc;
        closes              = 1'b0;
        if (i_state.inside_string) begin
            // ordinary string bytes fall through all three tests
            if (i_state.escape_pending) begin
                tracked.escape_pending = 1'b0;
            end else if (i_byte == CH_BSLASH) begin
                tracked.escape_pending = 1'b1;
            end else if (i_byte == CH_QUOTE) begin
                tracked.inside_string = 1'b0;
            end
        end else if (i_byte == CH_QUOTE) begin
            tracked.inside_string = 1'b1;
        end else if (i_byte == CH_OPEN) begin
            if (i_state.brace_depth != DEPTH_MAX) begin
                tracked.brace_depth = i_state.brace_depth + 8'd1;
            end
        end else if (i_byte == CH_CLOSE && i_state.brace_depth != 8'd0) begin
            tracked.brace_depth = i_state.brace_depth - 8'd1;
            closes              = (i_state.brace_depth == 8'd1);
        end
    end

    always_comb begin
        o_result    = '{stored: 1'b0, position: 8'd0, frame_end: FE_NONE,
                        frame_length: 8'd0, overflow_drop: 1'b0};
        o_state_nxt = i_state;
        priority if (is_term) begin
            if (i_state.frame_count != 8'd0) begin
                o_result.frame_end    = FE_LINE;
                o_result.frame_length = i_state.frame_count;
                o_state_nxt           = '0;
            end
        end else if (i_state.frame_count < limit) begin
            o_result.stored   = 1'b1;
            o_result.position = i_state.frame_count;
            if (closes) begin
                o_result.frame_end    = FE_BRACE;
                o_result.frame_length = count_inc;
                o_state_nxt           = '0;
            end else begin
                o_state_nxt = tracked;
            end
        end else begin
            o_result.overflow_drop = 1'b1;
            o_state_nxt            = '0;
        end
    end

endmodule

// ===== design/json_line_frame_splitter_core.sv =====
`timescale 1ns / 1ps
// json_line_frame_splitter_core: top level of the json line frame splitter
// depends on jlfs_pkg, jlfs_if.sv and jlfs_frame_logic
//
//  channel   direction  handshake        payload
//  i_in      sink       valid / ready    in_byte[7:0], chunk_end
//  o_out     source     valid / ready    out_byte, stored, position, frame_end,
//                                        frame_length, overflow_drop, chunk_done
//  i_cfg_*   write      i_cfg_wr_en      i_cfg_wr_data[7:0] -> max_frame_len
//
// one request per cycle sustained while o_out.ready is held; a request accepted into the
// input register moves on into the result register, from which it is offered as a
// result; these two registers stand around the logic
// i_rst_n synchronous active low: clears both stage valids and the stream state,
// max_frame_len returns to 255
// a stalled result holds in the output register while the input register still
// takes one request; with both full, i_in.ready drops until o_out.ready returns
module json_line_frame_splitter_core
    import jlfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    jlfs_in_if.sink    i_in,
    jlfs_out_if.source o_out,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data
);

    // configuration
    logic [7:0] r_max_len;

    // input register stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_chunk;

    // stream state carried from byte to byte
    t_frame_state r_state;
    t_frame_state n_state;

    // result register stage
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_chunk;
    t_frame_result r_out_res;
    t_frame_result n_res;

    logic out_adv;   // input stage moves into the result register
    logic in_take;   // request accepted into the input register

    assign out_adv    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || out_adv;
    assign in_take    = i_in.valid && i_in.ready;

    jlfs_frame_logic u_logic (
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .i_state     (r_state),
        .o_result    (n_res),
        .o_state_nxt (n_state)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            // input register keeps its request until it moves on
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (out_adv) begin
                r_in_valid <= 1'b0;
            end
            // result register fills on advance, empties when taken
            if (out_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            // stream state steps exactly once per byte
            if (out_adv) begin
                r_state <= n_state;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_in.in_byte;
            r_in_chunk <= i_in.chunk_end;
        end
        if (out_adv) begin
            r_out_byte  <= r_in_byte;
            r_out_chunk <= r_in_chunk;
            r_out_res   <= n_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.stored        = r_out_res.stored;
    assign o_out.position      = r_out_res.position;
    assign o_out.frame_end     = r_out_res.frame_end;
    assign o_out.frame_length  = r_out_res.frame_length;
    assign o_out.overflow_drop = r_out_res.overflow_drop;
    assign o_out.chunk_done    = r_out_chunk;

`ifndef NO_ASSERTIONS
    // an unaccepted result is never overwritten or dropped
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("pending result lost");

    // a frame end or discard leaves the stream state cleared
    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_adv && (n_res.frame_end != FE_NONE || n_res.overflow_drop)
        |=> r_state.frame_count == 8'd0 && r_state.brace_depth == 8'd0
            && !r_state.inside_string && !r_state.escape_pending)
        else $error("stream state not cleared after frame end");

    // a dropped byte neither stores nor ends a frame
    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.overflow_drop
        |-> !r_out_res.stored && r_out_res.frame_end == FE_NONE)
        else $error("overflow drop mixed with store or frame end");

    // a stored byte advances the frame count by one when no frame ends
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_adv && n_res.stored && n_res.frame_end == FE_NONE
        |=> r_state.frame_count == $past(r_state.frame_count) + 8'd1)
        else $error("frame count did not step on stored byte");
`endif

endmodule
